// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the filter block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define SVFM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SVFM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/svfm_pkg.sv =====
// ---------------------------------------------------------------------------
// svfm_pkg
// Widths, register indexes, datapath select codes and the command bundle
// shared by the controller and the datapath of the morphing SVF.
// ---------------------------------------------------------------------------
`default_nettype none

package svfm_pkg;

  localparam int SAMPLE_W  = 24;   // Q1.23 audio
  localparam int STATE_W   = 32;   // integrator width
  localparam int COEF_W    = 32;   // unsigned Q5.27 coefficients
  localparam int COEF_FRAC = 27;
  localparam int TRANS_W   = 16;   // signed Q2.14 morph values
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  // Widest intermediate (lowpass / second integrator before saturation)
  // stays below 2^55 for any register and sample values.
  localparam int VAL_W     = 56;
  localparam int MIX_W     = 48;   // lowpass and band-stop mix inputs clamped to +-(2^47-1)
  localparam int ACC_W     = 64;
  localparam int MIX_SHIFT = 14;
  localparam int UNITY_T   = 16384;
  localparam int WGT_W     = 15;   // crossfade weights 0..16384

  localparam logic [COEF_W-1:0]         COEF_ONE  = COEF_W'(1) << COEF_FRAC;
  localparam logic signed [TRANS_W-1:0] TBASE_RST = -TRANS_W'(UNITY_T);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RHO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TBASE  = 3'd4;

  typedef logic [2:0] opa_t;
  typedef logic [2:0] coef_t;
  typedef logic [2:0] wb_t;

  // Multiplier operand
  localparam opa_t OPA_Z1  = 3'd0;
  localparam opa_t OPA_T   = 3'd1;
  localparam opa_t OPA_HPF = 3'd2;
  localparam opa_t OPA_BPF = 3'd3;
  localparam opa_t OPA_MIX = 3'd4;
  localparam opa_t OPA_BSF = 3'd5;

  // Multiplier coefficient
  localparam coef_t CF_RHO   = 3'd0;
  localparam coef_t CF_ALPHA = 3'd1;
  localparam coef_t CF_GAIN  = 3'd2;
  localparam coef_t CF_DAMP  = 3'd3;
  localparam coef_t CF_WA    = 3'd4;
  localparam coef_t CF_WB    = 3'd5;

  // Write-back target
  localparam wb_t WB_NONE = 3'd0;
  localparam wb_t WB_T    = 3'd1;
  localparam wb_t WB_HPF  = 3'd2;
  localparam wb_t WB_BPF  = 3'd3;
  localparam wb_t WB_LPF  = 3'd4;
  localparam wb_t WB_BSF  = 3'd5;
  localparam wb_t WB_ACC0 = 3'd6;
  localparam wb_t WB_ACC1 = 3'd7;

  typedef struct packed {
    logic  load;      // capture an input beat
    logic  mul_en;
    logic  mul_hi;    // upper operand slice this cycle
    opa_t  opa;
    coef_t coef;
    wb_t   wb;
    logic  out_load;
  } svfm_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/svfm_ctrl.sv =====
// ---------------------------------------------------------------------------
// svfm_ctrl
// Sequencer for the morphing SVF: input/output handshakes and the fixed
// per-sample micro-op schedule driving the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module svfm_ctrl
  import svfm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output svfm_cmd_t cmd
);

  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_LAST = 5'd17;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (step_r == STEP_LAST) state_nxt = ST_FIN;
        else step_nxt = step_r + STEP_W'(1);
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Each coefficient product takes a low and a high pass through the shared
  // multiplier, then a write-back; independent products overlap write-backs.
  always_comb begin
    cmd          = '0;
    cmd.opa      = OPA_Z1;
    cmd.coef     = CF_RHO;
    cmd.wb       = WB_NONE;
    cmd.load     = (state_r == ST_IDLE) && in_valid;
    cmd.out_load = (state_r == ST_FIN) && out_free;
    if (state_r == ST_RUN) begin
      unique case (step_r)
        5'd0: begin
          cmd.mul_en = 1'b1; cmd.opa = OPA_Z1; cmd.coef = CF_RHO;
        end
        5'd1: begin
          cmd.mul_en = 1'b1; cmd.mul_hi = 1'b1; cmd.opa = OPA_Z1; cmd.coef = CF_RHO;
        end
        5'd2: cmd.wb = WB_T;
        5'd3: begin
          cmd.mul_en = 1'b1; cmd.opa = OPA_T; cmd.coef = CF_ALPHA;
        end
        5'd4: begin
          cmd.mul_en = 1'b1; cmd.mul_hi = 1'b1; cmd.opa = OPA_T; cmd.coef = CF_ALPHA;
        end
        5'd5: cmd.wb = WB_HPF;
        5'd6: begin
          cmd.mul_en = 1'b1; cmd.opa = OPA_HPF; cmd.coef = CF_GAIN;
        end
        5'd7: begin
          cmd.mul_en = 1'b1; cmd.mul_hi = 1'b1; cmd.opa = OPA_HPF; cmd.coef = CF_GAIN;
        end
        5'd8: cmd.wb = WB_BPF;
        5'd9: begin
          cmd.mul_en = 1'b1; cmd.opa = OPA_BPF; cmd.coef = CF_GAIN;
        end
        5'd10: begin
          cmd.mul_en = 1'b1; cmd.mul_hi = 1'b1; cmd.opa = OPA_BPF; cmd.coef = CF_GAIN;
        end
        5'd11: begin
          cmd.wb = WB_LPF;
          cmd.mul_en = 1'b1; cmd.opa = OPA_BPF; cmd.coef = CF_DAMP;
        end
        5'd12: begin
          cmd.mul_en = 1'b1; cmd.mul_hi = 1'b1; cmd.opa = OPA_BPF; cmd.coef = CF_DAMP;
        end
        5'd13: begin
          cmd.wb = WB_BSF;
          cmd.mul_en = 1'b1; cmd.opa = OPA_MIX; cmd.coef = CF_WA;
        end
        5'd14: begin
          cmd.mul_en = 1'b1; cmd.mul_hi = 1'b1; cmd.opa = OPA_MIX; cmd.coef = CF_WA;
        end
        5'd15: begin
          cmd.wb = WB_ACC0;
          cmd.mul_en = 1'b1; cmd.opa = OPA_BSF; cmd.coef = CF_WB;
        end
        5'd16: begin
          cmd.mul_en = 1'b1; cmd.mul_hi = 1'b1; cmd.opa = OPA_BSF; cmd.coef = CF_WB;
        end
        5'd17: cmd.wb = WB_ACC1;
        default: cmd.wb = WB_NONE;
      endcase
    end
  end

  `SVFM_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == ST_IDLE) && !out_valid_r, "reset did not return to idle")
  `SVFM_ASSERT(a_beat_starts_run, (in_valid && !in_stall) |=> (state_r == ST_RUN) && (step_r == '0), "accepted beat did not start the schedule")
  `SVFM_ASSERT(a_step_in_range, (state_r == ST_RUN) |-> (step_r <= STEP_LAST), "schedule step out of range")
  `SVFM_ASSERT(a_result_after_fin, $rose(out_valid_r) |-> $past(state_r == ST_FIN), "result raised outside finish")

endmodule

`default_nettype wire

// ===== hdl/svfm_dp.sv =====
// ---------------------------------------------------------------------------
// svfm_dp
// Datapath of the morphing SVF: coefficient registers, integrators, one
// shared 29x33 multiplier with slice accumulation, write-back adders,
// crossfade weights and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module svfm_dp
  import svfm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  svfm_cmd_t                  cmd,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic signed [TRANS_W-1:0]  in_tmod,
  output logic signed [SAMPLE_W-1:0] sample_out
);

  localparam int MA_W   = VAL_W - COEF_FRAC;   // operand slice, signed
  localparam int MB_W   = COEF_W + 1;
  localparam int PROD_W = MA_W + MB_W;
  localparam int LO_P_W = COEF_FRAC + COEF_W;  // low-slice product, unsigned
  localparam int TSUM_W = TRANS_W + 2;

  localparam logic signed [TSUM_W-1:0] T_HI = TSUM_W'(UNITY_T);
  localparam logic signed [TSUM_W-1:0] T_LO = -T_HI;
  localparam logic signed [ACC_W-1:0]  MIX_ROUND = ACC_W'(1) <<< (MIX_SHIFT - 1);

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [VAL_W:0] v);
    logic fits;
    fits = (v[VAL_W:STATE_W-1] == '0) || (v[VAL_W:STATE_W-1] == '1);
    if (fits) return v[STATE_W-1:0];
    return v[VAL_W] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
  endfunction

  // Symmetric clamp: the most negative code also folds to -(2^47-1).
  function automatic logic signed [MIX_W-1:0] clamp_mix(input logic signed [VAL_W-1:0] v);
    logic fits;
    logic is_min;
    fits   = (v[VAL_W-1:MIX_W-1] == '0) || (v[VAL_W-1:MIX_W-1] == '1);
    is_min = (v[MIX_W-1:0] == {1'b1, {(MIX_W-1){1'b0}}});
    if (fits && !is_min) return v[MIX_W-1:0];
    if (v[VAL_W-1]) return {1'b1, {(MIX_W-2){1'b0}}, 1'b1};
    return {1'b0, {(MIX_W-1){1'b1}}};
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic fits;
    fits = (v[ACC_W-1:SAMPLE_W-1] == '0) || (v[ACC_W-1:SAMPLE_W-1] == '1);
    if (fits) return v[SAMPLE_W-1:0];
    return v[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
  endfunction

  // Configuration and integrator state
  logic [COEF_W-1:0]         alpha0_r, gain_r, rho_r, damp_r;
  logic signed [TRANS_W-1:0] tbase_r;
  logic signed [STATE_W-1:0] z1_r, z2_r;

  // Per-sample working registers
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [VAL_W-1:0]    t_r, hpf_r, bpf_r;
  logic signed [MIX_W-1:0]    lpf_r, bsf_r;
  logic [WGT_W-1:0]           wa_r, wb_r;
  logic                       sel_lpf_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic [LO_P_W-1:0]          lo_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [SAMPLE_W-1:0] sample_out_r;

  logic signed [VAL_W-1:0]  z1_ext, z2_ext, x_ext, lpf_ext, bsf_ext;
  logic signed [VAL_W-1:0]  opa_val;
  logic [COEF_W-1:0]        coef_val;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] q_full;
  logic signed [VAL_W-1:0]  q;
  logic signed [VAL_W:0]    q_dbl;
  logic signed [ACC_W-1:0]  term;
  logic signed [VAL_W:0]    z1_new, z2_new;
  logic signed [TSUM_W-1:0] tsum, tcl;
  logic [WGT_W-1:0]         mag;
  logic signed [ACC_W-1:0]  acc_rnd, y_sh;

  assign z1_ext  = VAL_W'(z1_r);
  assign z2_ext  = VAL_W'(z2_r);
  assign x_ext   = VAL_W'(x_r);
  assign lpf_ext = VAL_W'(lpf_r);
  assign bsf_ext = VAL_W'(bsf_r);

  always_comb begin
    unique case (cmd.opa)
      OPA_Z1:  opa_val = z1_ext;
      OPA_T:   opa_val = t_r;
      OPA_HPF: opa_val = hpf_r;
      OPA_BPF: opa_val = bpf_r;
      OPA_MIX: opa_val = sel_lpf_r ? lpf_ext : hpf_r;
      OPA_BSF: opa_val = bsf_ext;
      default: opa_val = '0;
    endcase
  end

  always_comb begin
    unique case (cmd.coef)
      CF_RHO:   coef_val = rho_r;
      CF_ALPHA: coef_val = alpha0_r;
      CF_GAIN:  coef_val = gain_r;
      CF_DAMP:  coef_val = damp_r;
      CF_WA:    coef_val = COEF_W'(wa_r);
      CF_WB:    coef_val = COEF_W'(wb_r);
      default:  coef_val = '0;
    endcase
  end

  // Low slice is unsigned, high slice carries the sign.
  assign mul_a = cmd.mul_hi ? opa_val[VAL_W-1:COEF_FRAC]
                            : {{(MA_W-COEF_FRAC){1'b0}}, opa_val[COEF_FRAC-1:0]};
  assign mul_b = {1'b0, coef_val};
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // floor(a*c / 2^27) = hi_p + floor(lo_p / 2^27) with the split at bit 27
  assign q_full = prod_r + $signed({{(PROD_W-COEF_W){1'b0}}, lo_r[LO_P_W-1:COEF_FRAC]});
  assign q      = q_full[VAL_W-1:0];
  assign q_dbl  = {q, 1'b0};
  assign term   = (ACC_W'(prod_r) <<< COEF_FRAC) + $signed({{(ACC_W-LO_P_W){1'b0}}, lo_r});

  assign z1_new = (VAL_W+1)'(z1_ext) + q_dbl;
  assign z2_new = (VAL_W+1)'(z2_ext) + q_dbl;

  // Morph position and crossfade weights
  always_comb begin
    tsum = TSUM_W'(tbase_r) + (TSUM_W'(in_tmod) <<< 1);
    if (tsum > T_HI) tcl = T_HI;
    else if (tsum < T_LO) tcl = T_LO;
    else tcl = tsum;
    mag = tcl[TSUM_W-1] ? WGT_W'(-tcl) : WGT_W'(tcl);
  end

  assign acc_rnd = acc_r + MIX_ROUND;
  assign y_sh    = acc_rnd >>> MIX_SHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha0_r <= COEF_ONE;
      gain_r   <= COEF_ONE;
      rho_r    <= COEF_ONE;
      damp_r   <= COEF_ONE;
      tbase_r  <= TBASE_RST;
      z1_r     <= '0;
      z2_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ALPHA0: alpha0_r <= cfg_data[COEF_W-1:0];
          REG_GAIN:   gain_r   <= cfg_data[COEF_W-1:0];
          REG_RHO:    rho_r    <= cfg_data[COEF_W-1:0];
          REG_DAMP:   damp_r   <= cfg_data[COEF_W-1:0];
          REG_TBASE:  tbase_r  <= cfg_data[TRANS_W-1:0];
          default: ;
        endcase
      end
      if (cmd.wb == WB_BPF) z1_r <= sat_state(z1_new);
      if (cmd.wb == WB_LPF) z2_r <= sat_state(z2_new);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r       <= in_sample;
      t_r       <= VAL_W'(in_sample) - z2_ext;
      sel_lpf_r <= tcl[TSUM_W-1];
      wa_r      <= mag;
      wb_r      <= WGT_W'(UNITY_T) - mag;
    end
    if (cmd.mul_en) prod_r <= mul_p;
    if (cmd.mul_en && cmd.mul_hi) lo_r <= prod_r[LO_P_W-1:0];
    unique case (cmd.wb)
      WB_T:    t_r   <= t_r - q;
      WB_HPF:  hpf_r <= q;
      WB_BPF:  bpf_r <= z1_ext + q;
      WB_LPF:  lpf_r <= clamp_mix(z2_ext + q);
      WB_BSF:  bsf_r <= clamp_mix(x_ext - q);
      WB_ACC0: acc_r <= term;
      WB_ACC1: acc_r <= acc_r + term;
      default: ;
    endcase
    if (cmd.out_load) sample_out_r <= sat_out(y_sh);
  end

  assign sample_out = sample_out_r;

endmodule

`default_nettype wire

// ===== hdl/state_variable_filter_morph.sv =====
// ---------------------------------------------------------------------------
// state_variable_filter_morph
// Two-pole zero-delay-feedback state-variable filter whose output crossfades
// lowpass -> band-stop -> highpass under a modulated morph position.
// ---------------------------------------------------------------------------
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | in_sample_in, in_transition_mod
// out     | output    | out_valid / out_stall| out_sample_out
// cfg     | input     | cfg_we (write only)  | cfg_index, cfg_data
//
// Each sample runs 18 schedule steps on the single shared 29x33 multiplier
// (five coefficient products and two mix products, two slices each), then
// a finish step loads the output register and the sequencer returns to idle
// to take the next beat.
// in_stall is high from accept until the result moves into the output
// register; a stalled out holds the sequencer in its finish step.
// Synchronous reset zeroes the integrators and restores register defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module state_variable_filter_morph
  import svfm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic signed [TRANS_W-1:0]  in_transition_mod,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  svfm_cmd_t cmd;

  svfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  svfm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_sample  (in_sample_in),
    .in_tmod    (in_transition_mod),
    .sample_out (out_sample_out)
  );

endmodule

`default_nettype wire

// ===== tb/state_variable_filter_morph_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// state_variable_filter_morph_tb
// Self-checking bench for the morphing two-pole SVF. A directed set hits the
// sample and morph extremes, saturating and zeroed coefficients and ignored
// register writes. Random phases follow, with realistic or arbitrary
// coefficients. Each accepted beat is run through a bit-exact filter model
// and every output beat is compared in order. The sender bursts and the
// receiver stalls to a pattern chosen per phase.
// ---------------------------------------------------------------------------
`default_nettype none

module state_variable_filter_morph_tb
  import svfm_pkg::*;
();

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [TRANS_W-1:0]  tmod;
  } filter_item_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS, STALL_MASK} stall_style_t;

  localparam longint WIDE_LIM = (longint'(1) <<< 62) - 1;
  localparam longint MIX_LIM  = (longint'(1) <<< 47) - 1;
  localparam real    Q27      = 134217728.0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic signed [TRANS_W-1:0]  in_transition_mod = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data = '0;

  state_variable_filter_morph i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_in      (in_sample_in),
    .in_transition_mod (in_transition_mod),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample_out    (out_sample_out),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Filter model state and register copies
  logic [COEF_W-1:0] k_alpha0 = COEF_ONE;
  logic [COEF_W-1:0] k_gain   = COEF_ONE;
  logic [COEF_W-1:0] k_rho    = COEF_ONE;
  logic [COEF_W-1:0] k_damp   = COEF_ONE;
  longint            k_tbase  = -UNITY_T;
  longint            integ_one = 0;
  longint            integ_two = 0;

  filter_item_t               pending_items[$];
  logic signed [SAMPLE_W-1:0] expected_samples[$];
  int                         queued_total = 0;
  int                         accepted_total = 0;
  int                         mismatches = 0;

  int           max_burst = 1;
  int           max_gap = 0;
  stall_style_t stall_style = STALL_NONE;
  logic [15:0]  stall_mask = '0;

  function automatic longint clamp_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint sat_signed(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint add_sat(longint a, longint b);
    return clamp_mag(clamp_mag(a, WIDE_LIM) + clamp_mag(b, WIDE_LIM), WIDE_LIM);
  endfunction

  // floor(a * c / 2^27), clamped to the wide range
  function automatic longint coef_mul(longint a, logic [COEF_W-1:0] c);
    logic signed [127:0] wa;
    logic signed [127:0] wide;
    wa = clamp_mag(a, WIDE_LIM);
    wide = wa * $signed({96'b0, c});
    wide = wide >>> COEF_FRAC;
    if (wide > WIDE_LIM) return WIDE_LIM;
    if (wide < -WIDE_LIM) return -WIDE_LIM;
    return longint'(wide);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] morph_filter_step(
    logic signed [SAMPLE_W-1:0] xin,
    logic signed [TRANS_W-1:0]  tmod
  );
    longint x, z1, z2, d, hpf, bpf, lpf, bsf, pos, acc;
    x = xin;
    z1 = integ_one;
    z2 = integ_two;
    d = add_sat(x, -coef_mul(z1, k_rho));
    d = add_sat(d, -z2);
    hpf = coef_mul(d, k_alpha0);
    bpf = add_sat(coef_mul(hpf, k_gain), z1);
    lpf = add_sat(coef_mul(bpf, k_gain), z2);
    bsf = add_sat(x, -coef_mul(bpf, k_damp));
    integ_one = sat_signed(add_sat(coef_mul(hpf, k_gain), bpf), STATE_W);
    integ_two = sat_signed(add_sat(coef_mul(bpf, k_gain), lpf), STATE_W);

    pos = k_tbase + 2 * longint'(tmod);
    if (pos > UNITY_T) pos = UNITY_T;
    if (pos < -UNITY_T) pos = -UNITY_T;

    hpf = clamp_mag(hpf, MIX_LIM);
    lpf = clamp_mag(lpf, MIX_LIM);
    bsf = clamp_mag(bsf, MIX_LIM);
    if (pos < 0) acc = (UNITY_T + pos) * bsf + (-pos) * lpf;
    else         acc = pos * hpf + (UNITY_T - pos) * bsf;
    return SAMPLE_W'(sat_signed((acc + 8192) >>> MIX_SHIFT, SAMPLE_W));
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_ALPHA0: k_alpha0 = data;
      REG_GAIN:   k_gain   = data;
      REG_RHO:    k_rho    = data;
      REG_DAMP:   k_damp   = data;
      REG_TBASE:  k_tbase  = $signed(data[TRANS_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic program_filter(logic [COEF_W-1:0] alpha0, logic [COEF_W-1:0] gain,
                                logic [COEF_W-1:0] rho, logic [COEF_W-1:0] damp,
                                logic [TRANS_W-1:0] base_pos);
    write_reg(REG_ALPHA0, alpha0);
    write_reg(REG_GAIN, gain);
    write_reg(REG_RHO, rho);
    write_reg(REG_DAMP, damp);
    // upper data bits are don't-care for the morph base
    write_reg(REG_TBASE, {16'($urandom), base_pos});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_item(logic signed [SAMPLE_W-1:0] s, logic signed [TRANS_W-1:0] m);
    filter_item_t it;
    it.sample = s;
    it.tmod   = m;
    pending_items.push_back(it);
    queued_total++;
  endtask

  task automatic wait_idle();
    while (accepted_total != queued_total || expected_samples.size() != 0) @(posedge clk);
  endtask

  // Sender: bursts of beats separated by random gaps
  always @(posedge clk) begin : sender
    filter_item_t it;
    int burst_left;
    int gap_left;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_samples.push_back(morph_filter_step(in_sample_in, in_transition_mod));
        accepted_total++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          in_valid          <= 1'b1;
          in_sample_in      <= it.sample;
          in_transition_mod <= it.tmod;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, max_burst);
            gap_left   = $urandom_range(0, max_gap);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each output beat and drives its own stall pattern
  always @(posedge clk) begin : receiver
    logic signed [SAMPLE_W-1:0] want;
    int stall_run;
    int cyc;
    cyc++;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: sample_out beat with none expected, actual %0d", $time,
                   out_sample_out);
          mismatches++;
        end else begin
          want = expected_samples.pop_front();
          if (out_sample_out !== want) begin
            $display("%0t: sample_out expected %0d actual %0d", $time, want, out_sample_out);
            mismatches++;
          end
        end
      end
      case (stall_style)
        STALL_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_RUNS: begin
          if (stall_run > 0) begin
            stall_run--;
            out_stall <= 1'b1;
          end else if ($urandom_range(0, 15) == 0) begin
            stall_run = $urandom_range(1, 40);
            out_stall <= 1'b1;
          end else begin
            out_stall <= 1'b0;
          end
        end
        STALL_MASK: out_stall <= stall_mask[cyc % 16];
        default: out_stall <= 1'b0;
      endcase
    end
  end

  initial begin : stimulus
    logic signed [SAMPLE_W-1:0] last_sample;
    logic signed [SAMPLE_W-1:0] s;
    logic signed [TRANS_W-1:0]  m;
    logic [TRANS_W-1:0]         base_pos;
    real g, damp2;
    int pick;

    last_sample = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, no idling: sample and morph extremes, clamped morph sums
    queue_item(24'sh7FFFFF, 16'sd0);
    queue_item(24'sh800000, 16'sd0);
    queue_item(24'sd0, 16'sd0);
    queue_item(-24'sd1, 16'sd8192);
    queue_item(24'sh7FFFFF, 16'sh7FFF);
    queue_item(24'sh800000, 16'sh8000);
    queue_item(24'sh555555, 16'sd16384);
    queue_item(24'shAAAAAA, -16'sd16384);
    queue_item(24'sh123456, 16'sd4096);
    queue_item(24'sh7FFFFF, 16'sd12288);
    wait_idle();

    // Writes beyond the register list must be dropped
    for (int i = int'(REG_TBASE) + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), '1);
    // Largest coefficients: integrators and output run into saturation
    program_filter('1, '1, '1, '1, 16'sd16384);
    max_gap = 3;
    max_burst = 2;
    queue_item(24'sh7FFFFF, 16'sd0);
    queue_item(24'sh7FFFFF, -16'sd8192);
    queue_item(24'sh800000, 16'sd0);
    queue_item(24'sh800000, -16'sd16384);
    queue_item(24'sh7FFFFF, 16'sd4096);
    wait_idle();
    program_filter('1, '1, '1, '1, 16'sh7FFF);
    queue_item(24'sh800000, 16'sh8000);
    queue_item(24'sh7FFFFF, 16'sh7FFF);
    queue_item(24'sh400000, -16'sd1);
    wait_idle();

    // Zeroed coefficients and the most negative morph base
    program_filter('0, '0, '0, '0, 16'sh8000);
    queue_item(24'sh7FFFFF, 16'sh7FFF);
    queue_item(24'sh800000, 16'sd16384);
    queue_item(24'sh3FFFFF, 16'sh8000);
    wait_idle();

    for (int phase = 0; phase < 10; phase++) begin
      base_pos = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(0, 32768) - 16384);
      if ($urandom_range(0, 9) < 7) begin
        // stable filter from a random cutoff and damping
        g = real'($urandom_range(5, 3000)) / 1000.0;
        damp2 = real'($urandom_range(50, 2000)) / 1000.0;
        program_filter($rtoi(Q27 / (1.0 + damp2 * g + g * g)), $rtoi(g * Q27),
                       $rtoi((damp2 + g) * Q27), $rtoi(damp2 * Q27), base_pos);
      end else begin
        program_filter($urandom, $urandom, $urandom, $urandom, base_pos);
      end

      stall_style = stall_style_t'(phase % 4);
      // bit 15 of the stall pattern is cleared so the receiver always drains
      stall_mask  = 16'($urandom) & 16'h7FFF;
      case ($urandom_range(0, 3))
        0: max_gap = 0;
        1: max_gap = 3;
        2: max_gap = 12;
        default: max_gap = 30;
      endcase
      max_burst = $urandom_range(1, 16);

      for (int n = 0; n < 100; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50)      s = SAMPLE_W'($urandom);
        else if (pick < 70) s = SAMPLE_W'($urandom_range(0, 8192) - 4096);
        else if (pick < 85) s = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
        else                s = last_sample;   // held value: a step for the integrators
        last_sample = s;
        pick = $urandom_range(0, 9);
        if (pick < 7)      m = TRANS_W'($urandom_range(0, 16384) - 8192);
        else if (pick < 9) m = TRANS_W'($urandom_range(0, 32768) - 16384);
        else               m = TRANS_W'($urandom);
        queue_item(s, m);
      end
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
